// ===== design/fbrs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fbrs_pkg
// Shared constants, codes and controller/datapath interface types for the
// free bitmap range search block.
// ----------------------------------------------------------------------------
package fbrs_pkg;

  localparam int WORD_BITS    = 64;
  localparam int WB_W         = $clog2(WORD_BITS);
  localparam int MAP_SLOTS_DEF = 4096;
  localparam int SLOT_W       = 12;
  localparam int FUNC_W       = 2;
  localparam int USE_W        = 7;

  localparam logic [USE_W-1:0] USE_RESET = 7'd64;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_MARK_USED = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_MARK_FREE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SEARCH    = 2'd2;

  // what the finished item reports
  typedef enum logic [1:0] {
    RES_NONE,
    RES_MARK,
    RES_FOUND
  } res_kind_t;

  typedef struct packed {
    logic      load;
    logic      clr_step;
    logic      mark_rd;
    logic      mark_wr;
    logic      scan_issue;
    logic      enc;
    logic      res_load;
    res_kind_t res_kind;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_mark;
    logic is_search;
    logic mark_ok;
    logic search_empty;
    logic issue_last;
    logic rd_pending;
    logic hit;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ===== design/free_bitmap_range_search.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// free_bitmap_range_search
// Free-slot bitmap with range-limited mark used / mark free and lowest free
// slot search over the words in use.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  in        in_valid / in_ready    func, slot_index, range_low, range_high
//  out       out_valid / out_ready  accepted, free_slot
//  cfg       cfg_valid / cfg_ready  words_in_use
//
//  after reset a clearing sweep sets every map word to all ones, one word a
//  cycle; no item is taken meanwhile
//  an applied mark does a read, modify, write of its map word; a refused mark,
//  undefined op or empty search reads no map word; a search reads the scanned
//  words, one map word read a cycle
//  one item in work at a time; its result waits until the output register frees
// ----------------------------------------------------------------------------
module free_bitmap_range_search #(
  parameter int MAP_SLOTS = fbrs_pkg::MAP_SLOTS_DEF
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire  [fbrs_pkg::FUNC_W-1:0]   func,
  input  wire  [fbrs_pkg::SLOT_W-1:0]   slot_index,
  input  wire  [fbrs_pkg::SLOT_W-1:0]   range_low,
  input  wire  [fbrs_pkg::SLOT_W-1:0]   range_high,
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire  [fbrs_pkg::USE_W-1:0]    words_in_use,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic                          accepted,
  output logic [fbrs_pkg::SLOT_W-1:0]   free_slot
);

  // command and status between sequencer and datapath
  fbrs_pkg::cmd_t    cmd;
  fbrs_pkg::status_t st;

  fbrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // map memory, range masks, scan pipeline and output register
  fbrs_dpath #(
    .MAP_SLOTS (MAP_SLOTS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .words_in_use (words_in_use),
    .func         (func),
    .slot_index   (slot_index),
    .range_low    (range_low),
    .range_high   (range_high),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .accepted     (accepted),
    .free_slot    (free_slot)
  );

  // sequencer issues at most one command a cycle
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.clr_step, cmd.mark_rd, cmd.mark_wr,
              cmd.scan_issue, cmd.enc, cmd.res_load}))
    else $error("more than one datapath command in a cycle");

  // no item is taken before the clearing sweep has finished
  a_ready_after_clear: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> st.clr_done)
    else $error("item taken during clearing sweep");

  // a result is only loaded into a free output register and then shows
  a_res_load: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> st.out_free ##1 out_valid)
    else $error("result load into busy output register");

  // a rejected or not-found item never reports a slot
  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !accepted) |-> (free_slot == '0))
    else $error("slot reported without acceptance");

endmodule
`default_nettype wire

// ===== design/fbrs_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fbrs_ctrl
// Sequencer for the free map: clearing sweep, mark read-modify-write and
// pipelined word scan for search.
// ----------------------------------------------------------------------------
module fbrs_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  input  fbrs_pkg::status_t st,
  output fbrs_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_MARK_WR,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t                state;
  state_t                state_next;
  fbrs_pkg::res_kind_t   kind;
  fbrs_pkg::res_kind_t   kind_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.res_kind = kind;
    state_next = state;
    kind_next  = kind;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (st.is_mark && st.mark_ok) begin
          cmd.mark_rd = 1'b1;
          state_next  = S_MARK_WR;
        end else if (st.is_search && !st.search_empty) begin
          cmd.scan_issue = 1'b1;
          state_next     = st.issue_last ? S_DRAIN : S_SCAN;
        end else begin
          kind_next  = fbrs_pkg::RES_NONE;
          state_next = S_DONE;
        end
      end
      S_MARK_WR: begin
        cmd.mark_wr = 1'b1;
        kind_next   = fbrs_pkg::RES_MARK;
        state_next  = S_DONE;
      end
      S_SCAN: begin
        if (st.hit) begin
          cmd.enc    = 1'b1;
          kind_next  = fbrs_pkg::RES_FOUND;
          state_next = S_DONE;
        end else begin
          cmd.scan_issue = 1'b1;
          if (st.issue_last) state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        priority if (st.hit) begin
          cmd.enc    = 1'b1;
          kind_next  = fbrs_pkg::RES_FOUND;
          state_next = S_DONE;
        end else if (!st.rd_pending) begin
          kind_next  = fbrs_pkg::RES_NONE;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      kind  <= fbrs_pkg::RES_NONE;
    end else begin
      state <= state_next;
      kind  <= kind_next;
    end
  end

endmodule
`default_nettype wire

// ===== design/fbrs_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fbrs_dpath
// Free map memory, item registers, range masks, scan pipeline, lowest set
// bit encoder and output register.
// ----------------------------------------------------------------------------
module fbrs_dpath #(
  parameter int MAP_SLOTS = fbrs_pkg::MAP_SLOTS_DEF
) (
  input  wire                             clk,
  input  wire                             rst,
  input  fbrs_pkg::cmd_t                  cmd,
  output fbrs_pkg::status_t               st,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire  [fbrs_pkg::USE_W-1:0]      words_in_use,
  input  wire  [fbrs_pkg::FUNC_W-1:0]     func,
  input  wire  [fbrs_pkg::SLOT_W-1:0]     slot_index,
  input  wire  [fbrs_pkg::SLOT_W-1:0]     range_low,
  input  wire  [fbrs_pkg::SLOT_W-1:0]     range_high,
  output logic                            out_valid,
  input  wire                             out_ready,
  output logic                            accepted,
  output logic [fbrs_pkg::SLOT_W-1:0]     free_slot
);

  localparam int WBITS     = fbrs_pkg::WORD_BITS;
  localparam int WB_W      = fbrs_pkg::WB_W;
  localparam int SLOT_W    = fbrs_pkg::SLOT_W;
  localparam int MAP_WORDS = MAP_SLOTS / fbrs_pkg::WORD_BITS;
  localparam int WA        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CMP_W     = ((WA > fbrs_pkg::USE_W) ? WA : fbrs_pkg::USE_W) + 1;
  localparam int SC_W      = ($clog2(MAP_SLOTS + 1) > SLOT_W) ?
                             $clog2(MAP_SLOTS + 1) : SLOT_W + 1;

  function automatic logic [WB_W-1:0] lowest_set(input logic [WBITS-1:0] w);
    logic [WB_W-1:0] n;
    n = '0;
    for (int i = WBITS - 1; i >= 0; i--) begin
      if (w[i]) n = WB_W'(i);
    end
    return n;
  endfunction

  logic [WBITS-1:0] mem [MAP_WORDS];

  logic [fbrs_pkg::USE_W-1:0]  use_words;
  logic [WA-1:0]               clr_cnt;

  // item registers
  logic [fbrs_pkg::FUNC_W-1:0] func_r;
  logic [SLOT_W-1:0]           idx_r;
  logic [CMP_W-1:0]            lo_w_r;
  logic [CMP_W-1:0]            hi_w_r;
  logic [WBITS-1:0]            lo_mask;
  logic [WBITS-1:0]            hi_mask;
  logic [WA-1:0]               last_w;
  logic [WA-1:0]               cur;
  logic                        mark_ok;
  logic                        empty;

  // scan pipeline
  logic [WA-1:0]               rd_addr;
  logic [WBITS-1:0]            rd_data;
  logic                        rd_vld;
  logic [WA-1:0]               rd_w;
  logic                        hit_vld;
  logic [WA-1:0]               hit_w;
  logic [WBITS-1:0]            hit_bits;
  logic [SLOT_W-1:0]           slot_r;

  // load-time decode
  logic [CMP_W-1:0]            lo_w_c, hi_w_c, used_c, last_c, words_c;
  logic                        mark_ok_c, empty_c;
  logic [WBITS-1:0]            masked;
  logic                        wr_en;
  logic [WA-1:0]               wr_addr;
  logic [WBITS-1:0]            wr_data;
  logic [WBITS-1:0]            bit_sel;

  assign cfg_ready = 1'b1;

  always_comb begin
    lo_w_c  = CMP_W'(range_low[SLOT_W-1:WB_W]);
    hi_w_c  = CMP_W'(range_high[SLOT_W-1:WB_W]);
    words_c = CMP_W'(MAP_WORDS);
    used_c  = (CMP_W'(use_words) > words_c) ? words_c : CMP_W'(use_words);
    last_c  = (hi_w_c > used_c - CMP_W'(1)) ? used_c - CMP_W'(1) : hi_w_c;
    empty_c = (used_c == '0) || (range_low > range_high) || (lo_w_c > last_c);
    mark_ok_c = (slot_index >= range_low) && (slot_index <= range_high) &&
                (SC_W'(slot_index) < SC_W'(MAP_SLOTS));
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= func;
      idx_r   <= slot_index;
      lo_w_r  <= lo_w_c;
      hi_w_r  <= hi_w_c;
      lo_mask <= {WBITS{1'b1}} << range_low[WB_W-1:0];
      hi_mask <= {WBITS{1'b1}} >> (WB_W'(WBITS - 1) - range_high[WB_W-1:0]);
      last_w  <= WA'(last_c);
      cur     <= WA'(lo_w_c);
      mark_ok <= mark_ok_c;
      empty   <= empty_c;
    end else if (cmd.scan_issue) begin
      cur <= cur + WA'(1);
    end
  end

  // memory: one read and one write port, read data registered
  assign rd_addr = cmd.mark_rd ? WA'(idx_r[SLOT_W-1:WB_W]) : cur;
  assign bit_sel = WBITS'(1) << idx_r[WB_W-1:0];

  always_comb begin
    wr_en   = cmd.clr_step || cmd.mark_wr;
    wr_addr = cmd.clr_step ? clr_cnt : WA'(idx_r[SLOT_W-1:WB_W]);
    priority if (cmd.clr_step) wr_data = {WBITS{1'b1}};
    else if (func_r == fbrs_pkg::FUNC_MARK_USED) wr_data = rd_data & ~bit_sel;
    else wr_data = rd_data | bit_sel;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  // range masking of the word just read
  always_comb begin
    masked = rd_data;
    if (CMP_W'(rd_w) == lo_w_r) masked = masked & lo_mask;
    if (CMP_W'(rd_w) == hi_w_r) masked = masked & hi_mask;
  end

  always_ff @(posedge clk) begin
    rd_w     <= cur;
    hit_w    <= rd_w;
    hit_bits <= masked;
    if (cmd.enc) slot_r <= SLOT_W'({hit_w, lowest_set(hit_bits)});
    if (cmd.res_load) begin
      accepted  <= (cmd.res_kind != fbrs_pkg::RES_NONE);
      free_slot <= (cmd.res_kind == fbrs_pkg::RES_FOUND) ? slot_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      use_words <= fbrs_pkg::USE_RESET;
      clr_cnt   <= '0;
      rd_vld    <= 1'b0;
      hit_vld   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) use_words <= words_in_use;
      if (cmd.clr_step && !st.clr_done) clr_cnt <= clr_cnt + WA'(1);
      rd_vld  <= cmd.scan_issue;
      hit_vld <= rd_vld && (masked != '0);
      if (cmd.res_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_comb begin
    st.clr_done     = (clr_cnt == WA'(MAP_WORDS - 1));
    st.is_mark      = (func_r == fbrs_pkg::FUNC_MARK_USED) ||
                      (func_r == fbrs_pkg::FUNC_MARK_FREE);
    st.is_search    = (func_r == fbrs_pkg::FUNC_SEARCH);
    st.mark_ok      = mark_ok;
    st.search_empty = empty;
    st.issue_last   = (cur == last_w);
    st.rd_pending   = rd_vld;
    st.hit          = hit_vld;
    st.out_free     = !out_valid || out_ready;
  end

endmodule
`default_nettype wire
